// File: hw/rtl/wcrl_pkg.sv
// Shared types, widths and codes for the weighted color ramp lookup.
package wcrl_pkg;

  localparam int MAX_STOPS = 16;
  localparam int IDX_W     = $clog2(MAX_STOPS);
  localparam int CNT_W     = $clog2(MAX_STOPS + 1);
  localparam int WGT_W     = 16;
  localparam int TOT_W     = 20;
  localparam int POS_W     = 17;
  localparam int FRAC_W    = 16;
  localparam int CH_W      = 8;
  localparam int COL_W     = 3 * CH_W;
  localparam int CUM_W     = WGT_W + CNT_W;
  localparam int V_W       = POS_W + TOT_W;
  localparam int CMP_W     = (V_W > CUM_W + FRAC_W) ? V_W : CUM_W + FRAC_W;
  localparam int NUM_W     = WGT_W + FRAC_W;
  localparam int WSUM_W    = WGT_W + 1;
  localparam int DIVD_W    = CH_W + WSUM_W;
  localparam int PD_W      = CH_W + 1 + NUM_W + 1;
  localparam int QBIT_W    = $clog2(CH_W);

  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << FRAC_W;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_SMOOTH  = 2'd2;
  localparam logic [1:0] OP_STEPPED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] RES_FIXED = 2'd0;
  localparam logic [1:0] RES_PICK  = 2'd1;
  localparam logic [1:0] RES_BLEND = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [WGT_W-1:0] stop_weight;
    logic [CH_W-1:0]  stop_red;
    logic [CH_W-1:0]  stop_green;
    logic [CH_W-1:0]  stop_blue;
    logic [POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [1:0]      status;
  } out_item_t;

  typedef struct packed {
    logic              capture;
    logic              decode;
    logic              clear;
    logic              append;
    logic              scan;
    logic              bld_a;
    logic              bld_b;
    logic              bld_c;
    logic              div_step;
    logic [QBIT_W-1:0] div_bit;
    logic              res_load;
    logic [1:0]        res_sel;
    logic [1:0]        res_status;
    logic              push;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       full;
    logic       scan_end;
    logic       blend_go;
  } sts_t;

endpackage

// File: hw/rtl/wcrl_ctrl.sv
// Controller state machine sequencing decode, band scan, blend and division.
module wcrl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wcrl_pkg::sts_t    sts,
  output wcrl_pkg::cmd_t    cmd
);
  import wcrl_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_PICK   = 4'd3;
  localparam logic [3:0] S_BLDA   = 4'd4;
  localparam logic [3:0] S_BLDB   = 4'd5;
  localparam logic [3:0] S_BLDC   = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [QBIT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode  = 1'b1;
        cmd.res_sel = RES_FIXED;
        unique case (sts.op)
          OP_CLEAR: begin
            cmd.clear      = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_OK;
            state_nxt      = S_DONE;
          end
          OP_APPEND: begin
            cmd.res_load   = 1'b1;
            cmd.append     = !sts.full;
            cmd.res_status = sts.full ? ST_FULL : ST_OK;
            state_nxt      = S_DONE;
          end
          OP_SMOOTH, OP_STEPPED: begin
            if (sts.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_nxt = sts.blend_go ? S_BLDA : S_PICK;
        end
      end
      S_PICK: begin
        cmd.res_load   = 1'b1;
        cmd.res_sel    = RES_PICK;
        cmd.res_status = ST_OK;
        state_nxt      = S_DONE;
      end
      S_BLDA: begin
        cmd.bld_a = 1'b1;
        state_nxt = S_BLDB;
      end
      S_BLDB: begin
        cmd.bld_b = 1'b1;
        state_nxt = S_BLDC;
      end
      S_BLDC: begin
        cmd.bld_c   = 1'b1;
        div_cnt_nxt = QBIT_W'(CH_W - 1);
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_bit  = div_cnt_r;
        if (div_cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          div_cnt_nxt = div_cnt_r - QBIT_W'(1);
        end
      end
      S_FIN: begin
        cmd.res_load   = 1'b1;
        cmd.res_sel    = RES_BLEND;
        cmd.res_status = ST_OK;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_valid_r || out_ready))
    else $error("result pushed over an untaken transaction");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BLDC) |=> (state_r == S_DIV && div_cnt_r == QBIT_W'(CH_W - 1)))
    else $error("division did not start at the top quotient bit");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE))
    else $error("accepted transaction not decoded");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> (state_r == S_DONE))
    else $error("finished result dropped while output stalled");

endmodule

// File: hw/rtl/wcrl_dp.sv
// Datapath: stop stores, scaling multiply, band scan, blend products and divider lanes.
module wcrl_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  wcrl_pkg::in_item_t  in_data,
  input  wcrl_pkg::cmd_t      cmd,
  output wcrl_pkg::sts_t      sts,
  output wcrl_pkg::out_item_t out_data
);
  import wcrl_pkg::*;

  logic [WGT_W-1:0] wmem [MAX_STOPS];
  logic [COL_W-1:0] cmem [MAX_STOPS];

  in_item_t         item_r;
  logic [CNT_W-1:0] count_r;
  logic [TOT_W-1:0] total_r;
  logic [WGT_W-1:0] w_rd_r;
  logic [COL_W-1:0] c_rd_r;
  logic [V_W-1:0]   v_r;
  logic [IDX_W-1:0] cur_idx_r;
  logic [CUM_W-1:0] cum_r;
  logic [WGT_W-1:0] wi_r;
  logic [COL_W-1:0] ca_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [NUM_W-1:0] num_r;
  logic [DIVD_W-1:0] prod_a_r [3];
  logic signed [PD_W-1:0] prod_d_r [3];
  logic [DIVD_W-1:0] rem_r [3];
  logic [CH_W-1:0]  quo_r [3];
  out_item_t        res_r;
  out_item_t        out_r;

  logic [POS_W-1:0] p_sat;
  logic [CUM_W-1:0] cum_new;
  logic [CMP_W-1:0] v_cmp, cum_cmp, lo_cmp;
  logic             smooth, hit, last;
  logic [IDX_W-1:0] w_addr, c_addr;
  logic [TOT_W:0]   tot_sum;

  logic [CH_W-1:0]        chan_a [3];
  logic [CH_W-1:0]        chan_b [3];
  logic signed [CH_W:0]   diff9 [3];
  logic signed [PD_W-1:0] diff_s [3];
  logic signed [PD_W-1:0] num_s;
  logic [DIVD_W-1:0]      a_ext [3];
  logic [DIVD_W-1:0]      w_ext;
  logic [DIVD_W-1:0]      prod_a_nxt [3];
  logic signed [PD_W-1:0] prod_d_nxt [3];
  logic signed [PD_W-1:0] blend_sum [3];
  logic [DIVD_W-1:0]      trial;

  assign p_sat   = (item_r.position > POS_ONE) ? POS_ONE : item_r.position;
  assign cum_new = cum_r + CUM_W'(w_rd_r);
  assign v_cmp   = CMP_W'(v_r);
  assign cum_cmp = CMP_W'({cum_new, {FRAC_W{1'b0}}});
  assign lo_cmp  = CMP_W'({cum_r, {FRAC_W{1'b0}}});
  assign smooth  = (item_r.opcode == OP_SMOOTH);
  // smooth bands are half-open, stepped bands include their upper edge
  assign hit     = smooth ? (v_cmp < cum_cmp) : (v_cmp <= cum_cmp);
  assign last    = (CNT_W'(cur_idx_r) == count_r - CNT_W'(1));
  assign tot_sum = (TOT_W + 1)'(total_r) + (TOT_W + 1)'(item_r.stop_weight);

  assign sts.op       = item_r.opcode;
  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == CNT_W'(MAX_STOPS));
  assign sts.scan_end = hit || last;
  assign sts.blend_go = smooth && hit && !last;

  assign w_addr = cmd.decode ? '0 : cur_idx_r + IDX_W'(1);
  assign c_addr = cmd.bld_a ? cur_idx_r + IDX_W'(1) : cur_idx_r;

  assign num_s = $signed(PD_W'(num_r));
  assign w_ext = DIVD_W'(wsum_r);
  assign trial = w_ext << cmd.div_bit;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      chan_a[ch]     = ca_r[ch*CH_W +: CH_W];
      chan_b[ch]     = c_rd_r[ch*CH_W +: CH_W];
      diff9[ch]      = $signed({1'b0, chan_b[ch]}) - $signed({1'b0, chan_a[ch]});
      diff_s[ch]     = PD_W'(diff9[ch]);
      a_ext[ch]      = DIVD_W'(chan_a[ch]);
      prod_a_nxt[ch] = a_ext[ch] * w_ext;
      prod_d_nxt[ch] = diff_s[ch] * num_s;
      blend_sum[ch]  = $signed(PD_W'(prod_a_r[ch])) + (prod_d_r[ch] >>> FRAC_W);
    end
  end

  // stop stores, read data registered
  always_ff @(posedge clk) begin
    w_rd_r <= wmem[w_addr];
    c_rd_r <= cmem[c_addr];
    if (cmd.append) begin
      wmem[count_r[IDX_W-1:0]] <= item_r.stop_weight;
      cmem[count_r[IDX_W-1:0]] <= {item_r.stop_red, item_r.stop_green, item_r.stop_blue};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
        total_r <= '0;
      end else if (cmd.append) begin
        count_r <= count_r + CNT_W'(1);
        total_r <= tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.decode) begin
      v_r       <= V_W'(p_sat) * V_W'(total_r);
      cur_idx_r <= '0;
      cum_r     <= '0;
    end
    if (cmd.scan) begin
      // advance until the band holding the point, or the last stop
      if (!(hit || last)) begin
        cum_r     <= cum_new;
        cur_idx_r <= cur_idx_r + IDX_W'(1);
      end else begin
        wi_r <= w_rd_r;
      end
    end
    if (cmd.bld_a) begin
      ca_r   <= c_rd_r;
      wsum_r <= WSUM_W'(wi_r) + WSUM_W'(w_rd_r);
      num_r  <= NUM_W'(v_cmp - lo_cmp);
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.bld_b) begin
        prod_a_r[ch] <= prod_a_nxt[ch];
        prod_d_r[ch] <= prod_d_nxt[ch];
      end
      if (cmd.bld_c) begin
        rem_r[ch] <= blend_sum[ch][DIVD_W-1:0];
        quo_r[ch] <= '0;
      end
      if (cmd.div_step && (rem_r[ch] >= trial)) begin
        rem_r[ch]              <= rem_r[ch] - trial;
        quo_r[ch][cmd.div_bit] <= 1'b1;
      end
    end
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_PICK: begin
          res_r <= {c_rd_r, ST_OK};
        end
        RES_BLEND: begin
          res_r <= {quo_r[2], quo_r[1], quo_r[0], ST_OK};
        end
        default: begin
          res_r <= {{COL_W{1'b0}}, cmd.res_status};
        end
      endcase
    end
    if (cmd.push) begin
      out_r <= res_r;
    end
  end

  assign out_data = out_r;

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (CNT_W'(cur_idx_r) < count_r))
    else $error("band scan ran past the stored stops");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> (count_r < CNT_W'(MAX_STOPS)))
    else $error("stop written into a full table");

endmodule

// File: hw/rtl/weighted_color_ramp_lookup_top.sv
// Top level of the weighted color ramp lookup: controller plus datapath.
//
//   channel   ports                          payload
//   input     in_valid / in_ready / in_data     opcode, stop weight and color, position
//   result    out_valid / out_ready / out_data  red, green, blue, status
//
// One transaction at a time; in_ready is high only while the controller is idle.
// Clear, append and failed queries go from accept through decode straight to the result.
// A query runs the one-per-cycle band scan, which visits k (1 to 16) stops, and then
// either a stepped or end-of-ramp pick or a blend;
// the blend adds three 8-step restoring divider lanes.
// Reset (rst_n low, synchronous) empties the table; a stalled result waits in the
// output register while the controller holds the next finished result.
module weighted_color_ramp_lookup_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wcrl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wcrl_pkg::out_item_t out_data
);
  import wcrl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wcrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wcrl_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
